/* design/lzgf_pkg.sv */
// lzgf_pkg.sv: shared types, constants and linearization tables of the zone fade controller
`timescale 1ns / 1ps
package lzgf_pkg;

    localparam int ZONE_COUNT  = 4;
    localparam int LINEAR_BITS = 16;

    localparam int LIN_W  = LINEAR_BITS + 1;
    localparam int ACC_W  = LIN_W + 8;
    localparam int IDX_W  = $clog2(ZONE_COUNT + 1);
    localparam int ADDR_W = 5;
    localparam int REG_COUNT = 6;

    // register indexes
    localparam logic [2:0] REG_ZONE0   = 3'd0;
    localparam logic [2:0] REG_ZONE1   = 3'd1;
    localparam logic [2:0] REG_ZONE2   = 3'd2;
    localparam logic [2:0] REG_ZONE3   = 3'd3;
    localparam logic [2:0] REG_AMBIENT = 3'd4;
    localparam logic [2:0] REG_INC     = 3'd5;

    localparam logic [23:0] ZONE_COLOR_RST = 24'h3700DC;
    localparam logic [23:0] AMBIENT_RST    = 24'h32000A;
    localparam logic [7:0]  INC_RST        = 8'd3;

    typedef struct packed {
        logic [3:0][23:0] zone_color;
        logic [23:0]      ambient_color;
        logic [7:0]       fade_increment;
    } t_cfg;

    typedef struct packed {
        logic       start;
        logic [7:0] src;
        logic [7:0] tgt;
        logic [7:0] k;
    } t_blend_req;

    typedef struct packed {
        logic       done;
        logic [7:0] code;
    } t_blend_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_BLEND,
        ST_FINISH,
        ST_EMIT
    } t_fade_state;

    typedef enum logic [2:0] {
        BP_IDLE,
        BP_MUL1,
        BP_MUL2,
        BP_DIV,
        BP_FIX,
        BP_SRCH,
        BP_DONE
    } t_blend_phase;

    typedef struct packed {
        logic [63:0]        m;
        logic signed [31:0] e;
    } t_xval;

    typedef logic [LIN_W-1:0] t_lin_tab [256];
    typedef logic [LIN_W-1:0] t_mid_tab [255];

    // shift-subtract division, used only while building the tables
    function automatic logic [63:0] f_divu(logic [63:0] n, logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_xval f_xnorm(logic [63:0] num, logic [63:0] den);
        t_xval       r;
        logic [63:0] n;
        int          sh;
        n  = num;
        sh = 0;
        for (int i = 0; i < 64; i++) begin
            if (n < den) begin
                n  = n << 1;
                sh = sh + 1;
            end
        end
        r.m = f_divu(n << 31, den);
        r.e = 32'(31 + sh);
        return r;
    endfunction

    function automatic t_xval f_xmul(t_xval a, t_xval b);
        t_xval       r;
        logic [63:0] p;
        p   = a.m[31:0] * b.m[31:0];
        r.e = a.e + b.e;
        if (p[63]) begin
            r.m = (p >> 32) + 64'(p[31]);
            r.e = r.e - 32;
        end else begin
            r.m = (p >> 31) + 64'(p[30]);
            r.e = r.e - 31;
        end
        if (r.m[32]) begin
            r.m = r.m >> 1;
            r.e = r.e - 1;
        end
        return r;
    endfunction

    function automatic logic f_xle(t_xval a, t_xval b);
        if (a.e != b.e) return a.e > b.e;
        return a.m <= b.m;
    endfunction

    // linear value of the srgb fraction a/b
    function automatic logic [63:0] f_lin_of(logic [63:0] a, logic [63:0] b);
        logic [63:0] n, d, full, lo, hi, mid;
        t_xval       x, x2, x4, x8, x12, t, t2, t5;
        if (a == 0) return 64'd0;
        if (a * 64'd100000 <= 64'd4045 * b) begin
            n = (a * 64'd100) << LINEAR_BITS;
            d = 64'd1292 * b;
            return f_divu(2 * n + d, 2 * d);
        end
        x    = f_xnorm(64'd1000 * a + 64'd55 * b, 64'd1055 * b);
        x2   = f_xmul(x, x);
        x4   = f_xmul(x2, x2);
        x8   = f_xmul(x4, x4);
        x12  = f_xmul(x8, x4);
        full = 64'd1 << (LINEAR_BITS + 1);
        lo   = 0;
        hi   = full;
        for (int it = 0; it < 64; it++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                t   = f_xnorm(mid, full);
                t2  = f_xmul(t, t);
                t5  = f_xmul(f_xmul(t2, t2), t);
                if (f_xle(t5, x12)) lo = mid;
                else hi = mid - 1;
            end
        end
        return (lo + 1) >> 1;
    endfunction

    function automatic t_lin_tab f_lin_tab();
        t_lin_tab tab;
        for (int c = 0; c < 256; c++) tab[c] = LIN_W'(f_lin_of(64'(c), 64'd255));
        return tab;
    endfunction

    function automatic t_mid_tab f_mid_tab();
        t_mid_tab tab;
        for (int c = 0; c < 255; c++) tab[c] = LIN_W'(f_lin_of(64'(2 * c + 1), 64'd510));
        return tab;
    endfunction

    localparam t_lin_tab LIN_TAB = f_lin_tab();
    localparam t_mid_tab MID_TAB = f_mid_tab();

endpackage

/* design/led_zone_gamma_fade_controller_top.sv */
// led_zone_gamma_fade_controller_top.sv: top level of the zone fade controller
//
//  channel   dir   transaction
//  s_axis    in    one tick: tdata motion_bits, daylight
//  m_axis    out   one zone color: tdata rgb, tuser zone, tlast on the final zone
//  apb       in    register writes and reads, always ready
//
//  a tick is accepted in the idle step; the ambient layer takes a read and a check step
//  and each zone a read, a check and an emit step; each fading layer adds a finish step
//  plus, per blended channel, two multiply steps, a divide with up to two fixups and an
//  8-step code search.
//  synchronous active-low reset clears every fade step through per-entry valid bits.
//  a new tick is taken only when the previous one has been fully issued; a stalled
//  output holds the sequencer in its emit step.
`timescale 1ns / 1ps
module led_zone_gamma_fade_controller_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,   // motion_bits[5:0], daylight[6]
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [23:0]                 o_m_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic [1:0]                  o_m_axis_tuser,   // zone[1:0]
    output logic                        o_m_axis_tlast,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [lzgf_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_pready
);

    lzgf_pkg::t_cfg       w_cfg;
    lzgf_pkg::t_blend_req w_req;
    lzgf_pkg::t_blend_rsp w_rsp;
    logic [23:0]          w_color;

    lzgf_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    lzgf_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    lzgf_fade u_fade (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_motion    (i_s_axis_tdata[5:0]),
        .i_daylight  (i_s_axis_tdata[6]),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_zone      (o_m_axis_tuser),
        .o_color     (w_color),
        .o_last      (o_m_axis_tlast),
        .o_req       (w_req),
        .i_rsp       (w_rsp)
    );

    // internal color is packed red high, stream puts red in the low byte
    assign o_m_axis_tdata = {w_color[7:0], w_color[15:8], w_color[23:16]};

endmodule

/* design/lzgf_cfg.sv */
// lzgf_cfg.sv: apb register file for colors and fade increment
`timescale 1ns / 1ps
module lzgf_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [lzgf_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_pready,
    output lzgf_pkg::t_cfg              o_cfg
);

    lzgf_pkg::t_cfg r_cfg;
    logic [2:0]     w_idx;
    logic           w_wr;

    assign w_idx    = i_paddr[4:2];
    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zone_color     <= {4{lzgf_pkg::ZONE_COLOR_RST}};
            r_cfg.ambient_color  <= lzgf_pkg::AMBIENT_RST;
            r_cfg.fade_increment <= lzgf_pkg::INC_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                lzgf_pkg::REG_ZONE0:   r_cfg.zone_color[0]  <= i_pwdata[23:0];
                lzgf_pkg::REG_ZONE1:   r_cfg.zone_color[1]  <= i_pwdata[23:0];
                lzgf_pkg::REG_ZONE2:   r_cfg.zone_color[2]  <= i_pwdata[23:0];
                lzgf_pkg::REG_ZONE3:   r_cfg.zone_color[3]  <= i_pwdata[23:0];
                lzgf_pkg::REG_AMBIENT: r_cfg.ambient_color  <= i_pwdata[23:0];
                lzgf_pkg::REG_INC:     r_cfg.fade_increment <= i_pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            lzgf_pkg::REG_ZONE0:   o_prdata = {8'd0, r_cfg.zone_color[0]};
            lzgf_pkg::REG_ZONE1:   o_prdata = {8'd0, r_cfg.zone_color[1]};
            lzgf_pkg::REG_ZONE2:   o_prdata = {8'd0, r_cfg.zone_color[2]};
            lzgf_pkg::REG_ZONE3:   o_prdata = {8'd0, r_cfg.zone_color[3]};
            lzgf_pkg::REG_AMBIENT: o_prdata = {8'd0, r_cfg.ambient_color};
            lzgf_pkg::REG_INC:     o_prdata = {24'd0, r_cfg.fade_increment};
            default:               o_prdata = 32'd0;
        endcase
    end

endmodule

/* design/lzgf_blend.sv */
// lzgf_blend.sv: one-channel linear-light blend, divide by 255 and code search
`timescale 1ns / 1ps
module lzgf_blend (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lzgf_pkg::t_blend_req i_req,
    output lzgf_pkg::t_blend_rsp o_rsp
);

    localparam int LIN_W = lzgf_pkg::LIN_W;
    localparam int ACC_W = lzgf_pkg::ACC_W;

    lzgf_pkg::t_blend_phase r_phase, n_phase;
    logic [7:0]       r_src, r_tgt, r_k;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [LIN_W-1:0] r_q, n_q;
    logic [ACC_W-1:0] r_rem, n_rem;
    logic [7:0]       r_code, n_code;
    logic [2:0]       r_bit, n_bit;

    logic [ACC_W+8:0] w_prod;
    logic [LIN_W-1:0] w_q0;
    logic [ACC_W-1:0] w_q0x;
    logic [7:0]       w_trial;
    logic [7:0]       w_tidx;

    // acc*257 >> 16 never overshoots acc/255
    assign w_prod  = {9'd0, r_acc} + ({9'd0, r_acc} << 8);
    assign w_q0    = LIN_W'(w_prod >> 16);
    assign w_q0x   = ACC_W'(w_q0);
    assign w_trial = r_code | (8'd1 << r_bit);
    assign w_tidx  = w_trial - 8'd1;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            lzgf_pkg::BP_IDLE: if (i_req.start) n_phase = lzgf_pkg::BP_MUL1;
            lzgf_pkg::BP_MUL1: n_phase = lzgf_pkg::BP_MUL2;
            lzgf_pkg::BP_MUL2: n_phase = lzgf_pkg::BP_DIV;
            lzgf_pkg::BP_DIV:  n_phase = lzgf_pkg::BP_FIX;
            lzgf_pkg::BP_FIX:  if (r_rem < ACC_W'(255)) n_phase = lzgf_pkg::BP_SRCH;
            lzgf_pkg::BP_SRCH: if (r_bit == 3'd0) n_phase = lzgf_pkg::BP_DONE;
            lzgf_pkg::BP_DONE: n_phase = lzgf_pkg::BP_IDLE;
            default:           n_phase = lzgf_pkg::BP_IDLE;
        endcase
    end

    always_comb begin
        n_acc  = r_acc;
        n_q    = r_q;
        n_rem  = r_rem;
        n_code = r_code;
        n_bit  = r_bit;
        unique case (r_phase)
            lzgf_pkg::BP_MUL1: n_acc = ACC_W'(lzgf_pkg::LIN_TAB[r_src])
                                       * ACC_W'(8'd255 - r_k);
            lzgf_pkg::BP_MUL2: n_acc = r_acc + ACC_W'(lzgf_pkg::LIN_TAB[r_tgt]) * ACC_W'(r_k)
                                       + ACC_W'(127);
            lzgf_pkg::BP_DIV: begin
                n_q   = w_q0;
                n_rem = r_acc - ((w_q0x << 8) - w_q0x);
            end
            lzgf_pkg::BP_FIX: begin
                if (r_rem >= ACC_W'(255)) begin
                    n_q   = r_q + LIN_W'(1);
                    n_rem = r_rem - ACC_W'(255);
                end else begin
                    n_code = 8'd0;
                    n_bit  = 3'd7;
                end
            end
            lzgf_pkg::BP_SRCH: begin
                if (lzgf_pkg::MID_TAB[w_tidx] <= r_q) n_code = w_trial;
                n_bit = r_bit - 3'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_phase <= lzgf_pkg::BP_IDLE;
        else          r_phase <= n_phase;
        if (r_phase == lzgf_pkg::BP_IDLE && i_req.start) begin
            r_src <= i_req.src;
            r_tgt <= i_req.tgt;
            r_k   <= i_req.k;
        end
        r_acc  <= n_acc;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_code <= n_code;
        r_bit  <= n_bit;
    end

    assign o_rsp.done = (r_phase == lzgf_pkg::BP_DONE);
    assign o_rsp.code = r_code;

endmodule

/* design/lzgf_fade.sv */
// lzgf_fade.sv: tick sequencer with the fade step memory and the result register
`timescale 1ns / 1ps
module lzgf_fade (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lzgf_pkg::t_cfg       i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [5:0]           i_motion,
    input  logic                 i_daylight,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_zone,
    output logic [23:0]          o_color,
    output logic                 o_last,
    output lzgf_pkg::t_blend_req o_req,
    input  lzgf_pkg::t_blend_rsp i_rsp
);

    localparam int IDX_W = lzgf_pkg::IDX_W;
    localparam int NENT  = lzgf_pkg::ZONE_COUNT + 1;
    localparam logic [IDX_W-1:0] AMB_IDX  = IDX_W'(lzgf_pkg::ZONE_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(lzgf_pkg::ZONE_COUNT - 1);

    lzgf_pkg::t_fade_state r_state, n_state;

    logic [7:0]       r_mem [NENT];
    logic [NENT-1:0]  r_vld;
    logic [7:0]       r_rdata;
    logic             r_rvld;

    logic [IDX_W-1:0] r_idx;
    logic [5:0]       r_motion;
    logic             r_day;
    logic [23:0]      r_amb, r_col, r_res;
    logic [7:0]       r_k;
    logic [1:0]       r_chan;
    logic             r_busy;
    logic             r_ovalid;
    logic [1:0]       r_ozone;
    logic [23:0]      r_ocolor;
    logic             r_olast;

    logic             w_is_amb, w_act, w_run, w_load, w_bdone;
    logic [7:0]       w_cur, w_knew;
    logic [8:0]       w_sum;
    logic [IDX_W+1:0] w_idx_ext;
    logic [3:0]       w_mbit;
    logic [15:0]      w_mot16;
    logic [23:0]      w_src, w_tgt;
    logic [4:0]       w_shift;

    assign w_is_amb  = (r_idx == AMB_IDX);
    assign w_idx_ext = {2'b00, r_idx};
    assign w_mot16   = {10'd0, r_motion};
    assign w_mbit    = 4'(r_idx) + 4'd1;
    assign w_act     = w_is_amb ? (r_motion != 6'd0) : w_mot16[w_mbit];
    assign w_cur     = r_rvld ? r_rdata : 8'd0;
    assign w_run     = !r_day && (w_act || w_cur != 8'd0);
    assign w_sum     = {1'b0, w_cur} + {1'b0, i_cfg.fade_increment};
    assign w_knew    = w_act ? 8'd1 : (w_sum[8] ? 8'd255 : w_sum[7:0]);
    assign w_src     = w_is_amb ? i_cfg.ambient_color : i_cfg.zone_color[w_idx_ext[1:0]];
    assign w_tgt     = w_is_amb ? 24'd0 : i_cfg.ambient_color;
    assign w_shift   = 5'd16 - {r_chan, 3'd0};
    assign w_load    = (r_state == lzgf_pkg::ST_EMIT) && (!r_ovalid || i_out_ready);
    assign w_bdone   = (r_state == lzgf_pkg::ST_BLEND) && r_busy && i_rsp.done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lzgf_pkg::ST_IDLE:  if (i_in_valid) n_state = lzgf_pkg::ST_READ;
            lzgf_pkg::ST_READ:  n_state = lzgf_pkg::ST_CHECK;
            lzgf_pkg::ST_CHECK: begin
                if (!w_run) n_state = w_is_amb ? lzgf_pkg::ST_READ : lzgf_pkg::ST_EMIT;
                else if (w_knew == 8'd255) n_state = lzgf_pkg::ST_FINISH;
                else n_state = lzgf_pkg::ST_BLEND;
            end
            lzgf_pkg::ST_BLEND: if (w_bdone && r_chan == 2'd2) n_state = lzgf_pkg::ST_FINISH;
            lzgf_pkg::ST_FINISH: n_state = w_is_amb ? lzgf_pkg::ST_READ : lzgf_pkg::ST_EMIT;
            lzgf_pkg::ST_EMIT: begin
                if (w_load) n_state = (r_idx == LAST_IDX) ? lzgf_pkg::ST_IDLE
                                                          : lzgf_pkg::ST_READ;
            end
            default: n_state = lzgf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == lzgf_pkg::ST_IDLE);
        o_req.start = (r_state == lzgf_pkg::ST_BLEND) && !r_busy;
        o_req.src   = 8'(w_src >> w_shift);
        o_req.tgt   = 8'(w_tgt >> w_shift);
        o_req.k     = r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lzgf_pkg::ST_IDLE;
            r_vld    <= '0;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_req.start) r_busy <= 1'b1;
            else if (w_bdone) r_busy <= 1'b0;
            if (w_load) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
            if (r_state == lzgf_pkg::ST_FINISH) r_vld[r_idx] <= 1'b1;
        end

        // step memory: one read, one write, never the same entry in one cycle
        if (r_state == lzgf_pkg::ST_READ) begin
            r_rdata <= r_mem[r_idx];
            r_rvld  <= r_vld[r_idx];
        end
        if (r_state == lzgf_pkg::ST_FINISH) r_mem[r_idx] <= (r_res == w_tgt) ? 8'd0 : r_k;

        unique case (r_state)
            lzgf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    r_motion <= i_motion;
                    r_day    <= i_daylight;
                    r_idx    <= AMB_IDX;
                    r_amb    <= 24'd0;
                end
            end
            lzgf_pkg::ST_CHECK: begin
                r_k    <= w_knew;
                r_chan <= 2'd0;
                if (!w_run) begin
                    if (w_is_amb) r_idx <= '0;
                    else r_col <= r_day ? 24'd0 : r_amb;
                end else if (w_knew == 8'd255) begin
                    r_res <= w_tgt;
                end
            end
            lzgf_pkg::ST_BLEND: begin
                if (w_bdone) begin
                    unique case (r_chan)
                        2'd0:    r_res[23:16] <= i_rsp.code;
                        2'd1:    r_res[15:8]  <= i_rsp.code;
                        default: r_res[7:0]   <= i_rsp.code;
                    endcase
                    r_chan <= r_chan + 2'd1;
                end
            end
            lzgf_pkg::ST_FINISH: begin
                if (w_is_amb) begin
                    r_amb <= r_res;
                    r_idx <= '0;
                end else begin
                    r_col <= r_res;
                end
            end
            lzgf_pkg::ST_EMIT: begin
                if (w_load) begin
                    r_ozone  <= w_idx_ext[1:0];
                    r_ocolor <= r_col;
                    r_olast  <= (r_idx == LAST_IDX);
                    r_idx    <= r_idx + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_zone      = r_ozone;
    assign o_color     = r_ocolor;
    assign o_last      = r_olast;

endmodule
